>>> hw/rtl/sbpp_pkg.sv
// shared constants for the scaled bitmap pixel packer
package sbpp_pkg;

   localparam int LANES = 8;
   localparam int LANE_W = 3;
   localparam int OFFS_W = 4;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR = 2'd2;

   localparam logic FMT_1BPP = 1'b0;
   localparam logic FMT_4BPP = 1'b1;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_RENDER = 1'b1;

   localparam int SCALE_MAX = 16;
   localparam int SCALE_IDX_W = 4;

   localparam logic [3:0] WHITE_NIBBLE = 4'h1;

endpackage

>>> hw/rtl/sbpp_store.sv
// bitmap byte store with one write port and two registered read ports
module sbpp_store #(
   parameter int DEPTH = 128,
   parameter int AW = 7
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr0,
   input  logic [AW-1:0] rd_addr1,
   output logic [7:0]    rd_data0,
   output logic [7:0]    rd_data1
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data0_ff;
   logic [7:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data0_ff <= mem_ff[rd_addr0];
         rd_data1_ff <= mem_ff[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

>>> hw/rtl/scaled_bitmap_pixel_packer_unit.sv
// Scaled bitmap pixel packer: holds a BITMAP_DIM x BITMAP_DIM one-bit bitmap and turns
// render beats into packed display bytes, upscaled by nearest neighbour. The block takes
// one beat per clock unless a waiting result stalls; a render result passes through the
// capture, reciprocal multiply, store read and pack stages in order, and the whole
// pipeline holds while rsp_ready is low with a result waiting. A load beat is captured,
// then written to the store, and gives no result; so do render beats whose row or byte
// column is beyond the display. Bitmap bytes must be loaded before a render reads them.
// Configuration must be written only while idle; the block does not enforce this.
module scaled_bitmap_pixel_packer_unit #(
   parameter int BITMAP_DIM = 32,
   parameter int MAX_ROWS = 1024,
   parameter int MAX_COLS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [sbpp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sbpp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [6:0]                           req_load_addr,
   input  logic [7:0]                           req_load_data,
   input  logic [9:0]                           req_disp_row,
   input  logic [8:0]                           req_byte_column,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_pixel_byte
);

   localparam int STORE_BYTES = (BITMAP_DIM * BITMAP_DIM + 7) / 8;
   localparam int AW = $clog2(STORE_BYTES);
   localparam int CW = $clog2(MAX_COLS);
   localparam int XW = (CW > 10) ? CW : 10;
   localparam int FRAC = XW + 4;
   localparam int RW = FRAC + 1;
   localparam int PW = XW + RW;
   localparam int BPR_1BPP = MAX_COLS / 8;
   localparam int BPR_4BPP = MAX_COLS / 2;

   // ceil(2^FRAC / s) for s = 1..16, exact quotient for every operand below 2^XW
   localparam logic [RW-1:0] RECIP [sbpp_pkg::SCALE_MAX] = '{
      RW'(((1 << FRAC) + 0) / 1),   RW'(((1 << FRAC) + 1) / 2),
      RW'(((1 << FRAC) + 2) / 3),   RW'(((1 << FRAC) + 3) / 4),
      RW'(((1 << FRAC) + 4) / 5),   RW'(((1 << FRAC) + 5) / 6),
      RW'(((1 << FRAC) + 6) / 7),   RW'(((1 << FRAC) + 7) / 8),
      RW'(((1 << FRAC) + 8) / 9),   RW'(((1 << FRAC) + 9) / 10),
      RW'(((1 << FRAC) + 10) / 11), RW'(((1 << FRAC) + 11) / 12),
      RW'(((1 << FRAC) + 12) / 13), RW'(((1 << FRAC) + 13) / 14),
      RW'(((1 << FRAC) + 14) / 15), RW'(((1 << FRAC) + 15) / 16)
   };

   // configuration
   logic [RW-1:0] recip_ff;
   logic          fmt_ff;
   logic [3:0]    fg_ff;
   logic [sbpp_pkg::SCALE_IDX_W-1:0] scale_idx;

   always_comb begin
      if (csr_wdata == '0) begin
         scale_idx = '0;
      end else if (32'(csr_wdata) > 32'(sbpp_pkg::SCALE_MAX)) begin
         scale_idx = sbpp_pkg::SCALE_IDX_W'(sbpp_pkg::SCALE_MAX - 1);
      end else begin
         scale_idx = sbpp_pkg::SCALE_IDX_W'(csr_wdata - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recip_ff <= RECIP[0];
         fmt_ff <= sbpp_pkg::FMT_1BPP;
         fg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            sbpp_pkg::CSR_SCALE_FACTOR: recip_ff <= RECIP[scale_idx];
            sbpp_pkg::CSR_PIXEL_FORMAT: fmt_ff <= csr_wdata[0];
            sbpp_pkg::CSR_FG_COLOR: fg_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // pipeline advance
   logic adv;
   logic accept;

   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign accept = req_valid && req_ready;

   // stage 1: capture, range checks, display columns
   logic          row_ok;
   logic          col_ok;
   logic          s1_ren_in;
   logic          s1_ld_in;
   logic          s1_ren_ff;
   logic          s1_ld_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [7:0]    s1_data_ff;
   logic [XW-1:0] s1_row_ff;
   logic [XW-1:0] s1_col_in [sbpp_pkg::LANES];
   logic [XW-1:0] s1_col_ff [sbpp_pkg::LANES];

   always_comb begin
      row_ok = 32'(req_disp_row) < 32'(MAX_ROWS);
      if (fmt_ff == sbpp_pkg::FMT_4BPP) begin
         col_ok = 32'(req_byte_column) < 32'(BPR_4BPP);
      end else begin
         col_ok = 32'(req_byte_column) < 32'(BPR_1BPP);
      end
      s1_ren_in = accept && (req_mode == sbpp_pkg::MODE_RENDER) && row_ok && col_ok;
      s1_ld_in = accept && (req_mode == sbpp_pkg::MODE_LOAD)
                 && (32'(req_load_addr) < 32'(STORE_BYTES));
      for (int k = 0; k < sbpp_pkg::LANES; k++) begin
         if (fmt_ff == sbpp_pkg::FMT_4BPP) begin
            s1_col_in[k] = XW'(32'(req_byte_column) * 2 + k);
         end else begin
            s1_col_in[k] = XW'(32'(req_byte_column) * 8 + k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ren_ff <= 1'b0;
         s1_ld_ff <= 1'b0;
      end else if (adv) begin
         s1_ren_ff <= s1_ren_in;
         s1_ld_ff <= s1_ld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_addr_ff <= AW'(req_load_addr);
         s1_data_ff <= req_load_data;
         s1_row_ff <= XW'(req_disp_row);
         s1_col_ff <= s1_col_in;
      end
   end

   // stage 2: quotients by reciprocal multiply
   logic [PW-1:0] row_prod;
   logic [PW-1:0] col_prod [sbpp_pkg::LANES];
   logic          s2_ren_ff;
   logic [XW-1:0] s2_br_ff;
   logic [XW-1:0] s2_bc_in [sbpp_pkg::LANES];
   logic [XW-1:0] s2_bc_ff [sbpp_pkg::LANES];

   always_comb begin
      row_prod = PW'(s1_row_ff) * PW'(recip_ff);
      for (int k = 0; k < sbpp_pkg::LANES; k++) begin
         col_prod[k] = PW'(s1_col_ff[k]) * PW'(recip_ff);
         s2_bc_in[k] = col_prod[k][FRAC +: XW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ren_ff <= 1'b0;
      end else if (adv) begin
         s2_ren_ff <= s1_ren_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_br_ff <= row_prod[FRAC +: XW];
         s2_bc_ff <= s2_bc_in;
      end
   end

   // stage 3: bitmap position and store read
   logic [31:0]                  pos0;
   logic [AW-1:0]                rd_addr0;
   logic [AW-1:0]                rd_addr1;
   logic                         s3_ren_ff;
   logic [sbpp_pkg::LANES-1:0]   s3_in_in;
   logic [sbpp_pkg::LANES-1:0]   s3_in_ff;
   logic [sbpp_pkg::OFFS_W-1:0]  s3_off_in [sbpp_pkg::LANES];
   logic [sbpp_pkg::OFFS_W-1:0]  s3_off_ff [sbpp_pkg::LANES];
   logic [7:0]                   rd_data0;
   logic [7:0]                   rd_data1;

   always_comb begin
      pos0 = 32'(s2_br_ff) * 32'(BITMAP_DIM) + 32'(s2_bc_ff[0]);
      rd_addr0 = AW'(pos0 >> 3);
      if (32'(rd_addr0) == 32'(STORE_BYTES - 1)) begin
         rd_addr1 = '0;
      end else begin
         rd_addr1 = rd_addr0 + 1'b1;
      end
      for (int k = 0; k < sbpp_pkg::LANES; k++) begin
         s3_in_in[k] = (32'(s2_br_ff) < 32'(BITMAP_DIM))
                       && (32'(s2_bc_ff[k]) < 32'(BITMAP_DIM));
         s3_off_in[k] = sbpp_pkg::OFFS_W'(pos0[2:0])
                        + sbpp_pkg::OFFS_W'(s2_bc_ff[k] - s2_bc_ff[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ren_ff <= 1'b0;
      end else if (adv) begin
         s3_ren_ff <= s2_ren_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_in_ff <= s3_in_in;
         s3_off_ff <= s3_off_in;
      end
   end

   sbpp_store #(
      .DEPTH(STORE_BYTES),
      .AW(AW)
   ) u_store (
      .clock(clock),
      .wr_en(s1_ld_ff && adv),
      .wr_addr(s1_addr_ff),
      .wr_data(s1_data_ff),
      .rd_en(adv),
      .rd_addr0(rd_addr0),
      .rd_addr1(rd_addr1),
      .rd_data0(rd_data0),
      .rd_data1(rd_data1)
   );

   // stage 4: pick pixels and pack the output byte
   logic [15:0]                window;
   logic [sbpp_pkg::LANES-1:0] px_set;
   logic [7:0]                 packed_in;
   logic                       rsp_valid_ff;
   logic [7:0]                 rsp_byte_ff;

   always_comb begin
      window = {rd_data0, rd_data1};
      for (int k = 0; k < sbpp_pkg::LANES; k++) begin
         px_set[k] = s3_in_ff[k] && window[sbpp_pkg::OFFS_W'(4'd15 - s3_off_ff[k])];
      end
      if (fmt_ff == sbpp_pkg::FMT_4BPP) begin
         packed_in[7:4] = px_set[0] ? fg_ff : sbpp_pkg::WHITE_NIBBLE;
         packed_in[3:0] = px_set[1] ? fg_ff : sbpp_pkg::WHITE_NIBBLE;
      end else begin
         for (int k = 0; k < sbpp_pkg::LANES; k++) begin
            packed_in[sbpp_pkg::LANE_W'(7 - k)] = !px_set[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s3_ren_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_byte_ff <= packed_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_byte = rsp_byte_ff;

endmodule

>>> hw/rtl/sbpp_checker.sv
// port-level checks for the scaled bitmap pixel packer
module sbpp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_pixel_byte
);

   // no result survives a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_byte))
      else $error("stalled result beat changed");

   // an empty output side never blocks the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side blocked with no result waiting");

   // a waiting result that is not taken blocks the request side
   a_block_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request beat taken while result side stalls");

endmodule

bind scaled_bitmap_pixel_packer_unit sbpp_checker u_sbpp_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_pixel_byte(rsp_pixel_byte)
);

>>> test/tb_scaled_bitmap_pixel_packer_unit.sv
// scaled bitmap pixel packer testbench: directed and random loads and renders vs a predictor
module tb_scaled_bitmap_pixel_packer_unit;

   localparam int BITMAP_DIM = 32;
   localparam int STORE_BYTES = BITMAP_DIM * BITMAP_DIM / 8;
   localparam int MAX_COLS = 1024;
   localparam int COLS_1BPP = MAX_COLS / 8;
   localparam int COLS_4BPP = MAX_COLS / 2;
   localparam int DRAIN_CYCLES = 12;
   localparam int MAX_GAP = 13;
   localparam int CHOKE_CYCLES = 260;
   localparam logic [sbpp_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic       mode;
      logic [6:0] load_addr;
      logic [7:0] load_data;
      logic [9:0] disp_row;
      logic [8:0] byte_column;
   } pixel_req_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [sbpp_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [sbpp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_mode = sbpp_pkg::MODE_LOAD;
   logic [6:0]                      req_load_addr = '0;
   logic [7:0]                      req_load_data = '0;
   logic [9:0]                      req_disp_row = '0;
   logic [8:0]                      req_byte_column = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [7:0]                      rsp_pixel_byte;

   pixel_req_type pending_reqs[$];
   pixel_req_type next_req;
   logic [7:0] expected_bytes[$];
   logic [7:0] bitmap_copy[STORE_BYTES];
   logic [4:0] cfg_scale = 5'd1;
   logic       cfg_format = sbpp_pkg::FMT_1BPP;
   logic [3:0] cfg_fg = 4'd0;
   int         send_max_gap = MAX_GAP;
   int         recv_max_gap = MAX_GAP;
   int         send_gap = 0;
   int         recv_hold = 0;
   int         choke_left = 0;
   int         results_seen = 0;
   int         error_count = 0;

   scaled_bitmap_pixel_packer_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_load_addr   (req_load_addr),
      .req_load_data   (req_load_data),
      .req_disp_row    (req_disp_row),
      .req_byte_column (req_byte_column),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_byte  (rsp_pixel_byte)
   );

   always #2 clock = ~clock;

   function automatic int scale_eff();
      if (cfg_scale == 5'd0) return 1;
      if (cfg_scale > 5'd16) return sbpp_pkg::SCALE_MAX;
      return int'(cfg_scale);
   endfunction

   function automatic logic pixel_on(int row, int col);
      int br;
      int bc;
      int pos;
      br = row / scale_eff();
      bc = col / scale_eff();
      if (br >= BITMAP_DIM || bc >= BITMAP_DIM) return 1'b0;
      pos = br * BITMAP_DIM + bc;
      return bitmap_copy[pos >> 3][7 - (pos & 7)];
   endfunction

   function automatic logic [7:0] pixel_byte_for(int row, int bcol);
      logic [7:0] b;
      b = '0;
      if (cfg_format == sbpp_pkg::FMT_1BPP) begin
         for (int k = 0; k < 8; k++)
            b[7 - k] = ~pixel_on(row, bcol * 8 + k);
      end else begin
         for (int k = 0; k < 2; k++)
            b[7 - 4 * k -: 4] = pixel_on(row, bcol * 2 + k) ? cfg_fg
                                                             : sbpp_pkg::WHITE_NIBBLE;
      end
      return b;
   endfunction

   function automatic pixel_req_type make_req(logic mode, int addr, int data, int row,
                                              int bcol);
      pixel_req_type r;
      r.mode = mode;
      r.load_addr = 7'(addr);
      r.load_data = 8'(data);
      r.disp_row = 10'(row);
      r.byte_column = 9'(bcol);
      return r;
   endfunction

   // mostly renders over the scaled bitmap, with loads and off-panel renders mixed in
   function automatic pixel_req_type random_req();
      pixel_req_type r;
      int span_rows;
      int span_cols;
      int pick;
      r = make_req(sbpp_pkg::MODE_RENDER, $urandom, $urandom, $urandom, $urandom);
      span_rows = BITMAP_DIM * scale_eff();
      span_cols = (cfg_format == sbpp_pkg::FMT_1BPP) ? span_rows / 8 : span_rows / 2;
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         r.mode = sbpp_pkg::MODE_LOAD;
      end else if (pick < 82) begin
         r.disp_row = 10'($urandom_range(0, span_rows + 1));
         r.byte_column = 9'($urandom_range(0, span_cols));
      end else if (pick < 90 && cfg_format == sbpp_pkg::FMT_1BPP) begin
         r.byte_column = 9'($urandom_range(COLS_1BPP, COLS_4BPP - 1));
      end
      return r;
   endfunction

   task automatic write_csr(input logic [sbpp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sbpp_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         sbpp_pkg::CSR_SCALE_FACTOR: cfg_scale = data;
         sbpp_pkg::CSR_PIXEL_FORMAT: cfg_format = data[0];
         sbpp_pkg::CSR_FG_COLOR:     cfg_fg = data[3:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_bytes.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [4:0] scale_w, input logic [4:0] fmt_w,
                            input logic [4:0] fg_w, input int n, input int smax, input int rmax);
      wait_idle();
      write_csr(sbpp_pkg::CSR_SCALE_FACTOR, scale_w);
      write_csr(sbpp_pkg::CSR_PIXEL_FORMAT, fmt_w);
      write_csr(sbpp_pkg::CSR_FG_COLOR, fg_w);
      @(negedge clock);
      send_max_gap = smax;
      recv_max_gap = rmax;
      repeat (n) pending_reqs.push_back(random_req());
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_mode == sbpp_pkg::MODE_LOAD)
               bitmap_copy[req_load_addr] = req_load_data;
            else if (cfg_format == sbpp_pkg::FMT_4BPP || req_byte_column < COLS_1BPP)
               expected_bytes.push_back(pixel_byte_for(req_disp_row, req_byte_column));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               next_req = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_mode <= next_req.mode;
               req_load_addr <= next_req.load_addr;
               req_load_data <= next_req.load_data;
               req_disp_row <= next_req.disp_row;
               req_byte_column <= next_req.byte_column;
               send_gap = $urandom_range(0, send_max_gap);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_hold = 0;
         choke_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t pixel_byte unexpected beat: expected none, actual %02h",
                        $time, rsp_pixel_byte);
               error_count++;
            end else if (expected_bytes[0] !== rsp_pixel_byte) begin
               $display("%0t pixel_byte mismatch: expected %02h, actual %02h",
                        $time, expected_bytes[0], rsp_pixel_byte);
               error_count++;
               void'(expected_bytes.pop_front());
            end else begin
               void'(expected_bytes.pop_front());
            end
            results_seen++;
            recv_hold = $urandom_range(0, recv_max_gap);
            // long back-pressure so the pipeline fills and stalls the request side
            if (results_seen == 40 || results_seen == 600)
               choke_left = CHOKE_CYCLES;
         end
         if (choke_left > 0) begin
            choke_left = choke_left - 1;
            rsp_ready <= 1'b0;
         end else if (recv_hold > 0) begin
            recv_hold = recv_hold - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #2000000;
      $display("tb_scaled_bitmap_pixel_packer_unit: errors");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill the whole bitmap so that no render reads an unwritten byte
      for (int a = 0; a < STORE_BYTES; a++)
         pending_reqs.push_back(make_req(sbpp_pkg::MODE_LOAD, a,
                                         (a % 16 == 0) ? 8'hFF : (a % 16 == 1) ? 8'h00 : $urandom,
                                         $urandom, $urandom));

      // directed, reset configuration: one bit per pixel, scale 1
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_LOAD, 0, 8'h80, 0, 0));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_LOAD, STORE_BYTES - 1, 8'h01, 1023, 511));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_LOAD, 3, 8'hFF, 0, 0));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 127, 255, 0, 3));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 31, 3));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 31, 0));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 32, 0));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 0, 4));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 1023, COLS_1BPP - 1));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 0, COLS_1BPP));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 1023, COLS_4BPP - 1));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 5, 2));

      // directed, four bits per pixel, scale zero, brightest foreground
      wait_idle();
      write_csr(CSR_UNUSED, sbpp_pkg::CSR_DATA_W'($urandom));
      write_csr(sbpp_pkg::CSR_SCALE_FACTOR, 5'd0);
      write_csr(sbpp_pkg::CSR_PIXEL_FORMAT, {4'b1111, sbpp_pkg::FMT_4BPP});
      write_csr(sbpp_pkg::CSR_FG_COLOR, 5'h0F);
      @(negedge clock);
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 31, 15));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 0, 16));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 16, 7));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 0, COLS_4BPP - 1));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 1023, COLS_4BPP - 1));
      pending_reqs.push_back(make_req(sbpp_pkg::MODE_RENDER, 0, 0, 32, 0));

      // random
      run_phase(5'd0, {4'b1111, sbpp_pkg::FMT_1BPP}, 5'h10, 150, MAX_GAP, MAX_GAP);
      run_phase(5'd16, {4'b0000, sbpp_pkg::FMT_4BPP}, 5'h0F, 150, 0, 0);
      run_phase(5'd31, {4'b1010, sbpp_pkg::FMT_1BPP}, 5'h00, 150, MAX_GAP, 0);
      run_phase(5'd17, {4'b0101, sbpp_pkg::FMT_4BPP}, 5'h1F, 150, 0, MAX_GAP);
      run_phase(5'd1, {4'b0000, sbpp_pkg::FMT_4BPP}, 5'h00, 150, MAX_GAP, MAX_GAP);
      for (int p = 0; p < 4; p++)
         run_phase(5'($urandom_range(2, 15)), 5'($urandom), 5'($urandom), 150,
                   ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP,
                   ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP);

      wait_idle();
      if (error_count == 0)
         $display("tb_scaled_bitmap_pixel_packer_unit: clean");
      else
         $display("tb_scaled_bitmap_pixel_packer_unit: errors");
      $finish;
   end

endmodule
